### hdl/word_frequency_counter_assert.svh
// Assertion macros shared by the word frequency counter RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef WORD_FREQUENCY_COUNTER_ASSERT_SVH
`define WORD_FREQUENCY_COUNTER_ASSERT_SVH

// Same-cycle implication
`define WFC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define WFC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/wfc_pkg.sv
// Package for the word frequency counter: record type and codes.
// Used by wfc_front, wfc_fifo, wfc_back and the top level.
package wfc_pkg;

	// Token length field sized for the largest supported word length
	localparam int LEN_W = 7;

	// Commands
	localparam logic [1:0] CMD_TEXT    = 2'd0;
	localparam logic [1:0] CMD_BLOCK   = 2'd1;
	localparam logic [1:0] CMD_END     = 2'd2;
	localparam logic [1:0] CMD_END_ALT = 2'd3;

	// Result status codes
	localparam logic [2:0] ST_EXISTING     = 3'd0;
	localparam logic [2:0] ST_NEW          = 3'd1;
	localparam logic [2:0] ST_BLOCKED      = 3'd2;
	localparam logic [2:0] ST_TABLE_FULL   = 3'd3;
	localparam logic [2:0] ST_BLOCK_STORED = 3'd4;
	localparam logic [2:0] ST_BLOCK_FULL   = 3'd5;

	// Front to back request: one stored character or one end of token
	typedef struct packed {
		logic             is_end;
		logic             kind;
		logic [LEN_W-1:0] len;
		logic [7:0]       chr;
	} rec_t;

endpackage

### hdl/wfc_front.sv
// Front end: splits the byte stream into tokens, trims and uppercases.
// Depends on wfc_pkg; feeds wfc_fifo with character and end requests.
module wfc_front #(
	parameter int MAX_WORD_LEN = 45
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,
	output logic             ready,
	input  logic [1:0]       command,
	input  logic [7:0]       character,
	output logic             push_valid,
	input  logic             push_ready,
	output wfc_pkg::rec_t    push_rec
);

	localparam int LW = wfc_pkg::LEN_W;

	logic [LW-1:0] tok_len_q;
	logic [LW-1:0] last_end_q;
	logic          seen_q;
	logic          kind_q;

	logic [7:0] upper;
	logic       letter, space, store, do_end, do_chr, take, clr, set_kind;

	// Character classes
	always_comb begin
		upper  = (character >= 8'h61 && character <= 8'h7A) ? character - 8'd32 : character;
		letter = (upper >= 8'h41 && upper <= 8'h5A);
		space  = (character == 8'h20) || (character >= 8'h09 && character <= 8'h0D);
		store  = (kind_q || seen_q || letter) && (tok_len_q < LW'(MAX_WORD_LEN));
	end

	// Decide what this request does
	always_comb begin
		do_end   = 1'b0;
		do_chr   = 1'b0;
		take     = 1'b0;
		clr      = 1'b0;
		set_kind = 1'b0;
		priority if (command[1]) begin
			do_end = 1'b1;
			take   = push_ready;
			clr    = push_ready;
		end else if (space) begin
			do_end   = 1'b1;
			take     = push_ready;
			clr      = push_ready;
			set_kind = push_ready;
		end else if (command[0] != kind_q) begin
			// finish the old token; the character is taken once the kind has switched
			do_end   = 1'b1;
			clr      = push_ready;
			set_kind = push_ready;
		end else begin
			do_chr = store;
			take   = store ? push_ready : 1'b1;
		end
	end

	assign ready      = take;
	assign push_valid = valid && (do_end || do_chr);

	always_comb begin
		push_rec.is_end = do_end;
		push_rec.kind   = kind_q;
		push_rec.len    = kind_q ? tok_len_q : last_end_q;
		push_rec.chr    = upper;
	end

	// Token state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_len_q  <= '0;
			last_end_q <= '0;
			seen_q     <= 1'b0;
			kind_q     <= 1'b0;
		end else if (valid) begin
			if (clr) begin
				tok_len_q  <= '0;
				last_end_q <= '0;
				seen_q     <= 1'b0;
			end else if (take) begin
				if (!kind_q && letter)
					seen_q <= 1'b1;
				if (store) begin
					tok_len_q <= tok_len_q + 1'b1;
					if (letter)
						last_end_q <= tok_len_q + 1'b1;
				end
			end
			if (set_kind)
				kind_q <= command[0];
		end
	end

endmodule

### hdl/wfc_fifo.sv
// Short request queue between front and back ends.
// Depends on wfc_pkg for the request record.
module wfc_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  wfc_pkg::rec_t push_rec,
	output logic          pop_valid,
	input  logic          pop_ready,
	output wfc_pkg::rec_t pop_rec
);

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	wfc_pkg::rec_t  buf_q [DEPTH];
	logic [PW:0]    wp_q, rp_q;

	assign push_ready = (wp_q - rp_q) != (PW+1)'(DEPTH);
	assign pop_valid  = wp_q != rp_q;
	assign pop_rec    = buf_q[rp_q[PW-1:0]];

	// Storage
	always_ff @(posedge clk) begin
		if (push_valid && push_ready)
			buf_q[wp_q[PW-1:0]] <= push_rec;
	end

	// Pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push_valid && push_ready)
				wp_q <= wp_q + 1'b1;
			if (pop_valid && pop_ready)
				rp_q <= rp_q + 1'b1;
		end
	end

endmodule

### hdl/wfc_back.sv
// Back end: blacklist and word table lookup, append and count update.
// Depends on wfc_pkg and word_frequency_counter_assert.svh.
`include "word_frequency_counter_assert.svh"
module wfc_back #(
	parameter int TABLE_DEPTH  = 256,
	parameter int MAX_WORD_LEN = 45,
	parameter int BLOCK_DEPTH  = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  wfc_pkg::rec_t pop_rec,
	output logic          valid,
	input  logic          ready,
	output logic [2:0]    status,
	output logic [7:0]    slot,
	output logic [31:0]   frequency,
	output logic [31:0]   total_words,
	output logic [8:0]    unique_words
);

	localparam int LW    = wfc_pkg::LEN_W;
	localparam int IXW   = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
	localparam int TIW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int BIW   = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
	localparam int UQW   = $clog2(TABLE_DEPTH + 1);
	localparam int BQW   = $clog2(BLOCK_DEPTH + 1);
	localparam int MAXD  = (TABLE_DEPTH > BLOCK_DEPTH) ? TABLE_DEPTH : BLOCK_DEPTH;
	localparam int CW    = $clog2(MAXD + 1);
	localparam int TAW   = (TABLE_DEPTH * MAX_WORD_LEN > 1) ?
		$clog2(TABLE_DEPTH * MAX_WORD_LEN) : 1;
	localparam int BAW   = (BLOCK_DEPTH * MAX_WORD_LEN > 1) ?
		$clog2(BLOCK_DEPTH * MAX_WORD_LEN) : 1;
	localparam int AW    = ((TAW > BAW) ? TAW : BAW) + 1;

	// States
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_LEN   = 4'd1;
	localparam logic [3:0] S_LENCK = 4'd2;
	localparam logic [3:0] S_CHR   = 4'd3;
	localparam logic [3:0] S_CHRCK = 4'd4;
	localparam logic [3:0] S_CPR   = 4'd5;
	localparam logic [3:0] S_CPW   = 4'd6;
	localparam logic [3:0] S_FIN   = 4'd7;
	localparam logic [3:0] S_EMIT  = 4'd8;

	// Memories
	logic [7:0]    tok_mem  [MAX_WORD_LEN];
	logic [7:0]    tchr_mem [TABLE_DEPTH * MAX_WORD_LEN];
	logic [LW-1:0] tlen_mem [TABLE_DEPTH];
	logic [31:0]   cnt_mem  [TABLE_DEPTH];
	logic [7:0]    bchr_mem [BLOCK_DEPTH * MAX_WORD_LEN];
	logic [LW-1:0] blen_mem [BLOCK_DEPTH];

	logic [7:0]    rd_tok, rd_tchr, rd_bchr;
	logic [LW-1:0] rd_tlen, rd_blen;
	logic [31:0]   rd_cnt;

	logic [3:0]    state_q;
	logic          scan_tbl_q;
	logic [LW-1:0] wlen_q, wr_q, j_q;
	logic [CW-1:0] i_q;
	logic [AW-1:0] base_q;
	logic [UQW-1:0] uniq_q;
	logic [BQW-1:0] bcnt_q;
	logic [31:0]   total_q;
	logic [2:0]    res_status_q;
	logic [CW-1:0] res_slot_q;
	logic [31:0]   res_freq_q;
	logic          out_valid_q;

	logic [AW-1:0] addr;
	logic [CW-1:0] limit;
	logic [7:0]    rd_chr;
	logic [LW-1:0] rd_len;
	logic [31:0]   cnt_inc;
	logic          out_free, pop;

	assign addr     = base_q + AW'(j_q);
	assign limit    = scan_tbl_q ? CW'(uniq_q) : CW'(bcnt_q);
	assign rd_chr   = scan_tbl_q ? rd_tchr : rd_bchr;
	assign rd_len   = scan_tbl_q ? rd_tlen : rd_blen;
	assign cnt_inc  = (rd_cnt == 32'hFFFF_FFFF) ? rd_cnt : rd_cnt + 32'd1;
	assign out_free = !out_valid_q || ready;
	assign pop_ready = (state_q == S_IDLE);
	assign pop      = pop_valid && pop_ready;

	// Registered reads
	always_ff @(posedge clk) begin
		rd_tok  <= tok_mem[j_q[IXW-1:0]];
		rd_tchr <= tchr_mem[addr[TAW-1:0]];
		rd_bchr <= bchr_mem[addr[BAW-1:0]];
		rd_tlen <= tlen_mem[i_q[TIW-1:0]];
		rd_blen <= blen_mem[i_q[BIW-1:0]];
		rd_cnt  <= cnt_mem[i_q[TIW-1:0]];
	end

	// Writes
	always_ff @(posedge clk) begin
		if (pop && !pop_rec.is_end && wr_q < LW'(MAX_WORD_LEN))
			tok_mem[wr_q[IXW-1:0]] <= pop_rec.chr;
		if (state_q == S_CPW && scan_tbl_q)
			tchr_mem[addr[TAW-1:0]] <= rd_tok;
		if (state_q == S_CPW && !scan_tbl_q)
			bchr_mem[addr[BAW-1:0]] <= rd_tok;
		if (state_q == S_FIN && scan_tbl_q) begin
			tlen_mem[i_q[TIW-1:0]] <= wlen_q;
			cnt_mem[i_q[TIW-1:0]]  <= 32'd1;
		end
		if (state_q == S_FIN && !scan_tbl_q)
			blen_mem[i_q[BIW-1:0]] <= wlen_q;
		if (state_q == S_CHRCK && scan_tbl_q && rd_tok == rd_chr && j_q + 1'b1 == wlen_q)
			cnt_mem[i_q[TIW-1:0]] <= cnt_inc;
	end

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			scan_tbl_q   <= 1'b0;
			wlen_q       <= '0;
			wr_q         <= '0;
			j_q          <= '0;
			i_q          <= '0;
			base_q       <= '0;
			uniq_q       <= '0;
			bcnt_q       <= '0;
			total_q      <= '0;
			res_status_q <= wfc_pkg::ST_EXISTING;
			res_slot_q   <= '0;
			res_freq_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (!pop_rec.is_end) begin
							wr_q <= wr_q + 1'b1;
						end else begin
							wr_q   <= '0;
							wlen_q <= pop_rec.len;
							j_q    <= '0;
							if (pop_rec.len != '0) begin
								if (pop_rec.kind) begin
									scan_tbl_q <= 1'b0;
									if (bcnt_q >= BQW'(BLOCK_DEPTH)) begin
										res_status_q <= wfc_pkg::ST_BLOCK_FULL;
										res_slot_q   <= '0;
										res_freq_q   <= '0;
										state_q      <= S_EMIT;
									end else begin
										i_q     <= CW'(bcnt_q);
										base_q  <= AW'(bcnt_q * MAX_WORD_LEN);
										state_q <= S_CPR;
									end
								end else begin
									scan_tbl_q <= 1'b0;
									i_q        <= '0;
									base_q     <= '0;
									state_q    <= S_LEN;
								end
							end
						end
					end
				end
				S_LEN: begin
					if (i_q >= limit) begin
						if (!scan_tbl_q) begin
							// not blacklisted: count it and search the table
							if (total_q != 32'hFFFF_FFFF)
								total_q <= total_q + 32'd1;
							scan_tbl_q <= 1'b1;
							i_q        <= '0;
							base_q     <= '0;
						end else if (uniq_q >= UQW'(TABLE_DEPTH)) begin
							res_status_q <= wfc_pkg::ST_TABLE_FULL;
							res_slot_q   <= '0;
							res_freq_q   <= '0;
							state_q      <= S_EMIT;
						end else begin
							j_q     <= '0;
							state_q <= S_CPR;
						end
					end else begin
						state_q <= S_LENCK;
					end
				end
				S_LENCK: begin
					if (rd_len == wlen_q) begin
						j_q     <= '0;
						state_q <= S_CHR;
					end else begin
						i_q     <= i_q + 1'b1;
						base_q  <= base_q + AW'(MAX_WORD_LEN);
						state_q <= S_LEN;
					end
				end
				S_CHR: state_q <= S_CHRCK;
				S_CHRCK: begin
					if (rd_tok != rd_chr) begin
						i_q     <= i_q + 1'b1;
						base_q  <= base_q + AW'(MAX_WORD_LEN);
						state_q <= S_LEN;
					end else if (j_q + 1'b1 != wlen_q) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_CHR;
					end else begin
						res_slot_q <= i_q;
						state_q    <= S_EMIT;
						if (scan_tbl_q) begin
							res_status_q <= wfc_pkg::ST_EXISTING;
							res_freq_q   <= cnt_inc;
						end else begin
							res_status_q <= wfc_pkg::ST_BLOCKED;
							res_freq_q   <= '0;
						end
					end
				end
				S_CPR: state_q <= S_CPW;
				S_CPW: begin
					if (j_q + 1'b1 == wlen_q) begin
						state_q <= S_FIN;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_CPR;
					end
				end
				S_FIN: begin
					res_slot_q <= i_q;
					state_q    <= S_EMIT;
					if (scan_tbl_q) begin
						uniq_q       <= uniq_q + 1'b1;
						res_status_q <= wfc_pkg::ST_NEW;
						res_freq_q   <= 32'd1;
					end else begin
						bcnt_q       <= bcnt_q + 1'b1;
						res_status_q <= wfc_pkg::ST_BLOCK_STORED;
						res_freq_q   <= '0;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			status       <= res_status_q;
			slot         <= 8'(res_slot_q);
			frequency    <= res_freq_q;
			total_words  <= total_q;
			unique_words <= 9'(uniq_q);
		end
	end

	assign valid = out_valid_q;

	`WFC_ASSERT_IMP(a_uniq_bound, 1'b1, uniq_q <= UQW'(TABLE_DEPTH), "word table overfilled")
	`WFC_ASSERT_IMP(a_bcnt_bound, 1'b1, bcnt_q <= BQW'(BLOCK_DEPTH), "blacklist overfilled")
	`WFC_ASSERT_NXT(a_append, state_q == S_FIN && scan_tbl_q, uniq_q == $past(uniq_q) + 1'b1, "append did not grow table")
	`WFC_ASSERT_IMP(a_hit_freq, state_q == S_EMIT && res_status_q == wfc_pkg::ST_EXISTING, res_freq_q != '0, "zero count on hit")

endmodule

### hdl/word_frequency_counter.sv
// Top level of the word frequency counter: front end, queue, back end.
// Depends on wfc_pkg, wfc_front, wfc_fifo and wfc_back.
//
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------
//  input    | in_valid/in_ready | command, character
//  result   | valid/ready       | status, slot, frequency, total_words,
//           |                   | unique_words
//
// The front takes one character per cycle while the queue has room, bar kind switches.
// A finished text word is scanned entry by entry, blacklist then table, by
// the back end's single lookup sequencer, which compares characters only
// for entries of equal length; appends copy a word one character at a time.
// Reset clears counts and token state; table contents are not cleared.
// A waiting result holds the back end; intake goes on until the queue fills.
module word_frequency_counter #(
	parameter int TABLE_DEPTH  = 256,
	parameter int MAX_WORD_LEN = 45,
	parameter int BLOCK_DEPTH  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  character,
	output logic        valid,
	input  logic        ready,
	output logic [2:0]  status,
	output logic [7:0]  slot,
	output logic [31:0] frequency,
	output logic [31:0] total_words,
	output logic [8:0]  unique_words
);

	logic          push_valid, push_ready, pop_valid, pop_ready;
	wfc_pkg::rec_t push_rec, pop_rec;

	// Tokenizer
	wfc_front #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_front (
		.clk(clk), .arst_n(arst_n),
		.valid(in_valid), .ready(in_ready),
		.command(command), .character(character),
		.push_valid(push_valid), .push_ready(push_ready), .push_rec(push_rec)
	);

	// Request queue
	wfc_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push_valid(push_valid), .push_ready(push_ready), .push_rec(push_rec),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop_rec(pop_rec)
	);

	// Lookup and update
	wfc_back #(
		.TABLE_DEPTH(TABLE_DEPTH), .MAX_WORD_LEN(MAX_WORD_LEN),
		.BLOCK_DEPTH(BLOCK_DEPTH)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop_rec(pop_rec),
		.valid(valid), .ready(ready),
		.status(status), .slot(slot), .frequency(frequency),
		.total_words(total_words), .unique_words(unique_words)
	);

endmodule
